// ===== rtl/core/sha256_byte_stream_hasher_core_defines.svh =====
// Assertion macros shared by the hasher checker.
`ifndef SHA256_BYTE_STREAM_HASHER_CORE_DEFINES_SVH
`define SHA256_BYTE_STREAM_HASHER_CORE_DEFINES_SVH
// Check that a condition implies a consequence in the same cycle.
`define SHA_ASSERT_IMP(label, clk, rst_n, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
		else $error(msg);
// Check that a condition implies a consequence in the next cycle.
`define SHA_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error(msg);
`endif

// ===== rtl/core/sha_pkg.sv =====
// ---------------------------------------------------------------------------
// SHA-256 hasher package
// Round constants, initial hash values and shared types.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package sha_pkg;
	localparam int FifoDepth = 4;

	// Word that passes from the front to the back.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       last;
	} item_t;

	function automatic logic [31:0] round_k(input logic [5:0] i);
		logic [31:0] k [64];
		k = '{
			32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
			32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
			32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
			32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
			32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
			32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
			32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
			32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
			32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
			32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
			32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
			32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
			32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
			32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
			32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
			32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
		return k[i];
	endfunction

	function automatic logic [31:0] init_h(input logic [2:0] i);
		logic [31:0] h [8];
		h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
			32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
		return h[i];
	endfunction

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction
endpackage
`default_nettype wire

// ===== rtl/core/sha_fifo.sv =====
// ---------------------------------------------------------------------------
// SHA item queue
// Small queue that parts the input front from the hashing back end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module sha_fifo #(
	parameter int Depth = sha_pkg::FifoDepth
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr_en,
	input  sha_pkg::item_t     wr_data,
	output logic               full,
	input  wire logic          rd_en,
	output sha_pkg::item_t     rd_data,
	output logic               rd_valid
);
	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
	sha_pkg::item_t mem_q [Depth];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;

	assign full     = (cnt_q == (AW+1)'(Depth));
	assign rd_valid = (cnt_q != '0);
	assign rd_data  = mem_q[rp_q];

	// Store a word at the write pointer.
	always_ff @(posedge clk) begin
		if (wr_en && !full) mem_q[wp_q] <= wr_data;
	end

	// Advance pointers and count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (wr_en && !full)
				wp_q <= (wp_q == AW'(Depth - 1)) ? '0 : wp_q + 1'b1;
			if (rd_en && rd_valid)
				rp_q <= (rp_q == AW'(Depth - 1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(wr_en && !full) - (AW+1)'(rd_en && rd_valid);
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/sha_engine.sv =====
// ---------------------------------------------------------------------------
// SHA compression back end
// Buffers bytes into a block, pads, runs 64 rounds and emits the digest.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module sha_engine (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  sha_pkg::item_t item,
	input  wire logic      item_valid,
	output logic           item_take,
	output logic [31:0]    digest_word,
	output logic [2:0]     word_index,
	output logic           last_word,
	output logic           empty,
	input  wire logic      pop
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PAD  = 3'd1;
	localparam logic [2:0] ST_LOAD = 3'd2;
	localparam logic [2:0] ST_RND  = 3'd3;
	localparam logic [2:0] ST_ADD  = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	logic [2:0]  state_q;
	logic [7:0]  blk_q [64];
	logic [5:0]  fill_q;
	logic [63:0] bits_q;
	logic [31:0] h_q [8];
	logic [31:0] v_q [8];
	logic [31:0] w_q [16];
	logic [5:0]  rnd_q;
	logic [6:0]  ld_q;
	logic        fin_q;     // message is finishing
	logic        len_q;     // length block is pending
	logic        pend_q;    // last word closed a full block; padding still to start
	logic [2:0]  oidx_q;
	logic [31:0] blkword_q;

	logic [31:0] s0, s1, wnew, wcur, t1, t2, e, a;
	logic [5:0]  ldw;

	assign item_take   = (state_q == ST_IDLE) && item_valid;
	assign empty       = (state_q != ST_OUT);
	assign digest_word = h_q[oidx_q];
	assign word_index  = oidx_q;
	assign last_word   = (oidx_q == 3'd7);

	// Message schedule and round logic.
	always_comb begin
		s0   = sha_pkg::rotr(w_q[1], 7) ^ sha_pkg::rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		s1   = sha_pkg::rotr(w_q[14], 17) ^ sha_pkg::rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		wnew = w_q[0] + s0 + w_q[9] + s1;
		wcur = w_q[0];
		e    = v_q[4];
		a    = v_q[0];
		t1   = v_q[7] + (sha_pkg::rotr(e, 6) ^ sha_pkg::rotr(e, 11) ^ sha_pkg::rotr(e, 25))
			+ ((e & v_q[5]) ^ (~e & v_q[6])) + sha_pkg::round_k(rnd_q) + wcur;
		t2   = (sha_pkg::rotr(a, 2) ^ sha_pkg::rotr(a, 13) ^ sha_pkg::rotr(a, 22))
			+ ((a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]));
		ldw  = ld_q[5:0];
	end

	// Byte store: read one byte a cycle while loading the schedule.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && item_take && item.has_byte)
			blk_q[fill_q] <= item.data_byte;
		else if (state_q == ST_PAD) begin
			if (fin_q && fill_q >= 6'd56 && len_q)
				blk_q[fill_q] <= bits_q[8*(6'd63 - fill_q) +: 8];
			else
				blk_q[fill_q] <= (!fin_q) ? 8'h80 : 8'h00;
		end
		blkword_q <= {blkword_q[23:0], blk_q[ldw]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
			bits_q  <= '0;
			rnd_q   <= '0;
			ld_q    <= '0;
			fin_q   <= 1'b0;
			len_q   <= 1'b0;
			pend_q  <= 1'b0;
			oidx_q  <= '0;
			for (int i = 0; i < 8; i++) h_q[i] <= sha_pkg::init_h(3'(i));
		end else begin
			case (state_q)
				// Take one word; store byte and decide what follows.
				ST_IDLE: begin
					if (item_take) begin
						if (item.has_byte) begin
							bits_q <= bits_q + 64'd8;
							fill_q <= fill_q + 6'd1;
							if (fill_q == 6'd63) begin
								fin_q <= 1'b0; len_q <= 1'b0; pend_q <= item.last;
								state_q <= ST_LOAD; ld_q <= '0;
							end else if (item.last) begin
								state_q <= ST_PAD; fin_q <= 1'b0; len_q <= 1'b0;
							end
						end else if (item.last) begin
							state_q <= ST_PAD; fin_q <= 1'b0; len_q <= 1'b0;
						end
					end
				end
				// Write 0x80 then zeros then length, one byte a cycle.
				ST_PAD: begin
					if (!fin_q) begin
						// first pad cycle writes 0x80 at fill position
						fin_q <= 1'b1;
						len_q <= (fill_q < 6'd56);
						fill_q <= fill_q + 6'd1;
						if (fill_q == 6'd63) begin state_q <= ST_LOAD; ld_q <= '0; end
					end else begin
						fill_q <= fill_q + 6'd1;
						if (fill_q == 6'd63) begin state_q <= ST_LOAD; ld_q <= '0; end
					end
				end
				// Shift bytes into the schedule window, four per word.
				ST_LOAD: begin
					ld_q <= ld_q + 7'd1;
					if (ld_q >= 7'd4 && ld_q[1:0] == 2'd0) begin
						for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
						w_q[15] <= blkword_q;
					end
					if (ld_q == 7'd64) begin
						state_q <= ST_RND; rnd_q <= '0;
						for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
					end
				end
				// One round per cycle.
				ST_RND: begin
					for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
					w_q[15] <= wnew;
					v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
					v_q[4] <= v_q[3] + t1;
					v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
					v_q[0] <= t1 + t2;
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) state_q <= ST_ADD;
				end
				// Fold the working state into the chaining value.
				ST_ADD: begin
					for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
					if (!fin_q) begin
						// start padding in a fresh block when the last word filled one
						state_q <= pend_q ? ST_PAD : ST_IDLE;
						pend_q <= 1'b0;
					end else if (!len_q) begin
						// pad overflowed into a second block
						len_q <= 1'b1; state_q <= ST_PAD;
					end else begin
						state_q <= ST_OUT; oidx_q <= '0;
					end
				end
				// Hand out eight digest words, then restart.
				ST_OUT: begin
					if (pop) begin
						oidx_q <= oidx_q + 3'd1;
						if (oidx_q == 3'd7) begin
							state_q <= ST_IDLE;
							fin_q <= 1'b0; len_q <= 1'b0; pend_q <= 1'b0;
							bits_q <= '0; fill_q <= '0;
							for (int i = 0; i < 8; i++) h_q[i] <= sha_pkg::init_h(3'(i));
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/sha256_byte_stream_hasher_core.sv =====
// A byte passes through the queue and then the back end; a full block then goes
// through the load, round and fold steps.
// Bytes wait in the queue while the single-round unit loads, hashes and folds a block.
// A last item costs one or two padded blocks before 8 digest words.
// Asynchronous active-low reset restores the initial hash values and empties the queue.
// ---------------------------------------------------------------------------
// SHA-256 byte stream hasher core
// Input queue in front of a one-round-per-cycle compression back end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module sha256_byte_stream_hasher_core #(
	parameter int FifoDepth = sha_pkg::FifoDepth
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [7:0]  data_byte,
	input  wire logic        has_byte,
	input  wire logic        last,
	output logic             empty,
	input  wire logic        pop,
	output logic [31:0]      digest_word,
	output logic [2:0]       word_index,
	output logic             last_word
);
	sha_pkg::item_t in_item, q_item;
	logic q_valid, q_take;

	assign in_item = '{data_byte: data_byte, has_byte: has_byte, last: last};

	// Queue words between front and back.
	sha_fifo #(.Depth(FifoDepth)) u_fifo (
		.clk(clk), .arst_n(arst_n), .wr_en(push), .wr_data(in_item), .full(full),
		.rd_en(q_take), .rd_data(q_item), .rd_valid(q_valid));

	// Hash the words.
	sha_engine u_engine (
		.clk(clk), .arst_n(arst_n), .item(q_item), .item_valid(q_valid),
		.item_take(q_take), .digest_word(digest_word), .word_index(word_index),
		.last_word(last_word), .empty(empty), .pop(pop));
endmodule
`default_nettype wire

// ===== rtl/core/sha_checker.sv =====
// ---------------------------------------------------------------------------
// SHA port checker
// Watches the result port ordering of the hasher core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "sha256_byte_stream_hasher_core_defines.svh"
module sha_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        empty,
	input wire logic        pop,
	input wire logic [2:0]  word_index,
	input wire logic        last_word
);
	`SHA_ASSERT_IMP(a_last_idx, clk, arst_n, !empty,
		last_word == (word_index == 3'd7), "last_word mismatch")
	`SHA_ASSERT_NEXT(a_idx_adv, clk, arst_n, !empty && pop && !last_word,
		!empty && word_index == $past(word_index) + 3'd1, "index skip")
	`SHA_ASSERT_NEXT(a_hold, clk, arst_n, !empty && !pop,
		!empty && $stable(word_index), "result dropped")
	`SHA_ASSERT_NEXT(a_end, clk, arst_n, !empty && pop && last_word, empty, "extra word")
endmodule
bind sha256_byte_stream_hasher_core sha_checker u_sha_checker (
	.clk(clk), .arst_n(arst_n), .empty(empty), .pop(pop),
	.word_index(word_index), .last_word(last_word));
`default_nettype wire

// ===== tb/testbench.sv =====
// ---------------------------------------------------------------------------
// SHA-256 byte stream hasher core testbench
// Feeds byte streams with random handshake gaps through the queue interface
// and compares every digest word against an in-bench SHA-256 model.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

class digest_board;
	logic [31:0] hash_state [8];
	logic [7:0]  block_bytes [64];
	int unsigned fill;
	logic [63:0] msg_bits;
	logic [31:0] pending_word [$];
	logic [2:0]  pending_index [$];
	logic        pending_last [$];
	int          errors;
	int          words_checked;
	int          digests;

	function void restart();
		for (int i = 0; i < 8; i++) hash_state[i] = sha_pkg::init_h(i[2:0]);
		fill = 0;
		msg_bits = '0;
	endfunction

	function new();
		errors = 0;
		words_checked = 0;
		digests = 0;
		restart();
	endfunction

	function logic [31:0] ror(logic [31:0] x, int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// Run one 64-round compression over the collected block.
	function void compress_block();
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] t1, t2, e, a;
		for (int i = 0; i < 16; i++)
			w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2],
				block_bytes[4*i+3]};
		for (int i = 16; i < 64; i++)
			w[i] = w[i-16] + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3))
				+ w[i-7] + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
		for (int i = 0; i < 8; i++) v[i] = hash_state[i];
		for (int i = 0; i < 64; i++) begin
			a = v[0];
			e = v[4];
			t1 = v[7] + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & v[5]) ^ (~e & v[6]))
				+ sha_pkg::round_k(i[5:0]) + w[i];
			t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) ^ 32'h0;
			t2 = t2 + ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++) hash_state[i] = hash_state[i] + v[i];
	endfunction

	// Note an accepted word and queue the digest it completes, if any.
	function void note_input(logic [7:0] data_byte, logic has_byte, logic last);
		logic [63:0] len;
		if (has_byte) begin
			block_bytes[fill] = data_byte;
			fill++;
			msg_bits += 64'd8;
			if (fill == 64) begin
				compress_block();
				fill = 0;
			end
		end
		if (!last) return;
		len = msg_bits;
		block_bytes[fill] = 8'h80;
		fill++;
		if (fill > 56) begin
			while (fill < 64) block_bytes[fill++] = 8'h00;
			compress_block();
			fill = 0;
		end
		while (fill < 56) block_bytes[fill++] = 8'h00;
		for (int i = 0; i < 8; i++) block_bytes[56+i] = len[63-8*i -: 8];
		compress_block();
		for (int i = 0; i < 8; i++) begin
			pending_word.push_back(hash_state[i]);
			pending_index.push_back(i[2:0]);
			pending_last.push_back(i == 7);
		end
		digests++;
		restart();
	endfunction

	// Compare one popped digest word with the oldest expectation.
	function void check_word(logic [31:0] digest_word, logic [2:0] word_index,
			logic last_word);
		logic [31:0] exp_word;
		logic [2:0]  exp_index;
		logic        exp_last;
		if (pending_word.size() == 0) begin
			$error("digest word %h popped with nothing expected", digest_word);
			errors++;
			return;
		end
		exp_word = pending_word.pop_front();
		exp_index = pending_index.pop_front();
		exp_last = pending_last.pop_front();
		words_checked++;
		if (digest_word !== exp_word) begin
			$error("digest_word expected %h actual %h", exp_word, digest_word);
			errors++;
		end
		if (word_index !== exp_index) begin
			$error("word_index expected %0d actual %0d", exp_index, word_index);
			errors++;
		end
		if (last_word !== exp_last) begin
			$error("last_word expected %0d actual %0d", exp_last, last_word);
			errors++;
		end
	endfunction
endclass

module testbench;
	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [7:0]  data_byte;
	logic        has_byte;
	logic        last;
	logic        empty;
	logic        pop;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	digest_board board = new();
	int          send_idle_pct;
	int          recv_stall_pct;
	int          hold_off_cycles;
	int          items_sent;
	int unsigned cycle_count;

	sha256_byte_stream_hasher_core DUT (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.data_byte(data_byte), .has_byte(has_byte), .last(last),
		.empty(empty), .pop(pop), .digest_word(digest_word),
		.word_index(word_index), .last_word(last_word)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Accept words and popped results at the rising edge.
	always @(posedge clk) begin
		if (arst_n && push && !full) board.note_input(data_byte, has_byte, last);
		if (arst_n && pop && !empty) board.check_word(digest_word, word_index, last_word);
	end

	// Drive pop at the falling edge; honor a long hold-off when one is requested.
	always @(negedge clk) begin
		if (hold_off_cycles > 0) begin
			hold_off_cycles--;
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Bound the run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > 3000000) begin
			$display("[sha256_byte_stream_hasher_core] ERROR");
			$finish;
		end
	end

	// Offer one word and hold it until accepted; push stays up for the next word.
	task automatic send_word(logic [7:0] b, logic hb, logic lst);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			data_byte <= 8'($urandom);
			has_byte <= 1'($urandom);
			last <= 1'($urandom);
			@(negedge clk);
		end
		push <= 1'b1;
		data_byte <= b;
		has_byte <= hb;
		last <= lst;
		@(posedge clk);
		while (full) @(posedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	// Send a whole message of random bytes, optionally closing with a bare item.
	task automatic send_message(int len, bit bare_close);
		for (int i = 0; i < len; i++)
			send_word(8'($urandom), 1'b1, (!bare_close && i == len - 1));
		if (bare_close || len == 0) send_word(8'($urandom), 1'b0, 1'b1);
	endtask

	// Drop push and wait until every expected digest word has been popped.
	task automatic drain();
		push <= 1'b0;
		while (board.pending_word.size() != 0) @(negedge clk);
	endtask

	task automatic random_phase(int idle_pct, int stall_pct, int count);
		int len;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		while (count > 0) begin
			case ($urandom_range(9))
				0: len = 0;
				1: len = $urandom_range(55, 57);
				2: len = $urandom_range(63, 65);
				3: len = $urandom_range(119, 121);
				default: len = $urandom_range(1, 20);
			endcase
			if (len + 1 > count) len = count - 1;
			if ($urandom_range(7) == 0) send_word(8'($urandom), 1'b0, 1'b0);
			send_message(len, $urandom_range(1));
			count -= (len + 1);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		data_byte = '0;
		has_byte = 1'b0;
		last = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off_cycles = 0;
		items_sent = 0;
		cycle_count = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: idle and ignored bytes, empty message, "abc", one-byte messages with and without a bare close.
		send_word(8'hff, 1'b0, 1'b0);
		send_word(8'hff, 1'b0, 1'b1);
		send_word(8'h61, 1'b1, 1'b0);
		send_word(8'h62, 1'b1, 1'b0);
		send_word(8'h63, 1'b1, 1'b1);
		send_word(8'h00, 1'b1, 1'b1);
		send_word(8'hff, 1'b1, 1'b0);
		send_word(8'h5a, 1'b0, 1'b1);
		drain();

		// Fill the queue behind a long receiver hold-off.
		hold_off_cycles = 2000;
		send_message(3, 1'b0);
		send_message(0, 1'b1);
		send_message(6, 1'b1);
		drain();

		random_phase(0, 0, 80);
		random_phase(83, 0, 75);
		drain();
		random_phase(0, 83, 75);
		random_phase(33, 33, 95);
		drain();
		repeat (400) @(posedge clk);

		$display("Sent %0d words; checked %0d digest words from %0d messages.",
			items_sent, board.words_checked, board.digests);
		if (board.errors == 0 && board.pending_word.size() == 0) begin
			$display("[sha256_byte_stream_hasher_core] OK");
		end else begin
			$display("[sha256_byte_stream_hasher_core] ERROR");
		end
		$finish;
	end
endmodule

`default_nettype wire

// ===== files.f =====
+incdir+rtl/core
rtl/core/sha_pkg.sv
rtl/core/sha_fifo.sv
rtl/core/sha_engine.sv
rtl/core/sha256_byte_stream_hasher_core.sv
rtl/core/sha_checker.sv
tb/testbench.sv
